// File: hw/rtl/text_page_break_finder_core_macros.svh
// Assertion macros used by the checker file of the page break finder.
`ifndef TEXT_PAGE_BREAK_FINDER_CORE_MACROS_SVH
`define TEXT_PAGE_BREAK_FINDER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define TPBF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define TPBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tpbf_pkg.sv
// Types and constants of the text page break finder.
package tpbf_pkg;

   // Configuration port geometry
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_PAGE_LENGTH = 2'd0;
   localparam logic [1:0] REG_RAW_OUTPUT  = 2'd1;
   localparam logic [1:0] REG_LINE_WIDTH  = 2'd2;

   // Register reset values
   localparam logic [7:0] PAGE_LENGTH_RESET = 8'd22;
   localparam logic       RAW_OUTPUT_RESET  = 1'b0;
   localparam logic [7:0] LINE_WIDTH_RESET  = 8'd79;

   // Characters with a meaning of their own
   localparam logic [7:0] CH_TICK  = 8'h60;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_NL    = 8'h0A;

   // Saturation limits of the counters
   localparam logic [7:0] COLUMN_MAX = 8'd255;
   localparam logic [8:0] LINE_MAX   = 9'd511;
   localparam logic [15:0] INDEX_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic        page_start;
      logic [15:0] page_index;
   } rsp_type;

endpackage

// File: hw/rtl/text_page_break_finder_core.sv
// Top level of the text page break finder: input stage, per-byte logic, result stage.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  tpbf_pkg::req_type (text byte, end of text)
//   rsp      out        rsp_valid / rsp_stall  tpbf_pkg::rsp_type (page start, page index)
//   csr      in         APB, pready tied high  page_length, raw_output, line_width
//
// One item per clock sustained while rsp_stall is low; each item passes the input register
// and then the output register from acceptance to result. The column, line, escape and page
// state update as an item leaves the input register, so consecutive bytes follow with no gap.
// Synchronous active-high reset clears both stages and loads the register defaults.
// req_stall rises only while a result waits in the output register and rsp_stall is high.
module text_page_break_finder_core #(
   parameter int PAGE_COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tpbf_pkg::req_type                    req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tpbf_pkg::rsp_type                    rsp_data,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tpbf_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [tpbf_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [tpbf_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int WideBits = (PAGE_COUNT_BITS > 16) ? PAGE_COUNT_BITS : 16;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_TICK,
      ESC_CARET
   } esc_type;

   typedef struct packed {
      logic [7:0] column;
      logic [8:0] line;
      logic       hold;
   } place_type;

   // Column and line effect of one character
   function automatic place_type place_char(input logic [7:0] column,
                                            input logic [8:0] line,
                                            input logic       hold,
                                            input logic [7:0] ch,
                                            input logic       no_width,
                                            input logic [7:0] plen,
                                            input logic [7:0] lwidth);
      place_type  res;
      logic [7:0] col_a;
      logic [8:0] line_up;
      res.column = column;
      res.line   = line;
      res.hold   = hold;
      col_a   = (no_width && (column != 8'd0)) ? column - 8'd1 : column;
      line_up = (line != tpbf_pkg::LINE_MAX) ? line + 9'd1 : line;
      if (ch == tpbf_pkg::CH_NL) begin
         res.column = 8'd1;
         res.line   = line_up;
      end else begin
         res.column = (col_a != tpbf_pkg::COLUMN_MAX) ? col_a + 8'd1 : col_a;
         if (col_a > lwidth) begin
            if (line >= {1'b0, plen}) begin
               res.hold = 1'b1;
            end else begin
               res.line   = line_up;
               res.column = 8'd1;
            end
         end
      end
      return res;
   endfunction

   // Configuration registers
   logic [7:0] plen_ff;
   logic       raw_ff;
   logic [7:0] lwidth_ff;

   // Pipeline registers
   logic              in_valid_ff;
   tpbf_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   tpbf_pkg::rsp_type out_data_ff;

   // Text state
   logic [7:0]                 column_ff, column_in;
   logic [8:0]                 line_ff, line_in;
   esc_type                    esc_ff, esc_in;
   logic                       hold_ff, hold_in;
   logic [PAGE_COUNT_BITS-1:0] page_ff, page_in;
   logic                       started_ff;
   logic                       start_in;
   tpbf_pkg::rsp_type          result_in;

   logic advance;
   logic csr_write;
   logic [WideBits-1:0] page_wide;

   // Handshake: the input register moves on when the output slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         tpbf_pkg::REG_PAGE_LENGTH: csr_prdata = {24'd0, plen_ff};
         tpbf_pkg::REG_RAW_OUTPUT:  csr_prdata = {31'd0, raw_ff};
         tpbf_pkg::REG_LINE_WIDTH:  csr_prdata = {24'd0, lwidth_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff   <= tpbf_pkg::PAGE_LENGTH_RESET;
         raw_ff    <= tpbf_pkg::RAW_OUTPUT_RESET;
         lwidth_ff <= tpbf_pkg::LINE_WIDTH_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            tpbf_pkg::REG_PAGE_LENGTH: plen_ff   <= csr_pwdata[7:0];
            tpbf_pkg::REG_RAW_OUTPUT:  raw_ff    <= csr_pwdata[0];
            tpbf_pkg::REG_LINE_WIDTH:  lwidth_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Per-byte logic: page break test, escape tracking, column and line update
   always_comb begin
      place_type pc;
      logic      brk;
      column_in = column_ff;
      line_in   = line_ff;
      esc_in    = esc_ff;
      hold_in   = hold_ff;
      page_in   = page_ff;
      start_in  = !started_ff;
      brk       = 1'b0;
      pc        = '0;

      unique case (esc_ff)
         ESC_NONE: begin
            brk = (plen_ff != 8'd0) && (line_ff > {1'b0, plen_ff}) && !hold_ff;
            if (brk) begin
               if (page_ff != '1) begin
                  page_in = page_ff + 1'b1;
               end
               column_in = 8'd1;
               line_in   = 9'd1;
               start_in  = 1'b1;
            end
            hold_in = 1'b0;
            if (!raw_ff && (in_data_ff.text_byte == tpbf_pkg::CH_TICK)) begin
               esc_in = ESC_TICK;
            end else begin
               pc = place_char(column_in, line_in, 1'b0, in_data_ff.text_byte, 1'b0,
                               plen_ff, lwidth_ff);
               column_in = pc.column;
               line_in   = pc.line;
               hold_in   = pc.hold;
            end
         end
         ESC_TICK: begin
            if (in_data_ff.text_byte == tpbf_pkg::CH_CARET) begin
               esc_in = ESC_CARET;
            end else begin
               // a doubled backtick prints, anything else is a colour code
               pc = place_char(column_ff, line_ff, hold_ff, in_data_ff.text_byte,
                               in_data_ff.text_byte != tpbf_pkg::CH_TICK,
                               plen_ff, lwidth_ff);
               column_in = pc.column;
               line_in   = pc.line;
               hold_in   = pc.hold;
               esc_in    = ESC_NONE;
            end
         end
         ESC_CARET: begin
            pc = place_char(column_ff, line_ff, hold_ff, in_data_ff.text_byte, 1'b1,
                            plen_ff, lwidth_ff);
            column_in = pc.column;
            line_in   = pc.line;
            hold_in   = pc.hold;
            esc_in    = ESC_NONE;
         end
         default: begin
            esc_in = ESC_NONE;
         end
      endcase
   end

   // Page index saturates at 16 bits
   assign page_wide = WideBits'(page_in);

   always_comb begin
      result_in.page_start = start_in;
      result_in.page_index = (page_wide > WideBits'(tpbf_pkg::INDEX_MAX)) ?
                             tpbf_pkg::INDEX_MAX : page_wide[15:0];
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result_in;
      end
   end

   // Text state; end of text returns it to the start of a new text
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= 8'd1;
         line_ff    <= 9'd1;
         esc_ff     <= ESC_NONE;
         hold_ff    <= 1'b0;
         page_ff    <= '0;
         started_ff <= 1'b0;
      end else if (advance) begin
         if (in_data_ff.end_of_text) begin
            column_ff  <= 8'd1;
            line_ff    <= 9'd1;
            esc_ff     <= ESC_NONE;
            hold_ff    <= 1'b0;
            page_ff    <= '0;
            started_ff <= 1'b0;
         end else begin
            column_ff  <= column_in;
            line_ff    <= line_in;
            esc_ff     <= esc_in;
            hold_ff    <= hold_in;
            page_ff    <= page_in;
            started_ff <= 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/tpbf_checker.sv
// Port-level checker of the page break finder and its bind to the top level.
`include "text_page_break_finder_core_macros.svh"

module tpbf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input tpbf_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tpbf_pkg::rsp_type rsp_data
);

   logic        rsp_fire;
   logic        have_last_ff;
   logic [15:0] last_index_ff;
   logic [16:0] last_next;
   logic        index_ok;

   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign last_next = {1'b0, last_index_ff} + 17'd1;
   assign index_ok  = (rsp_data.page_index == 16'd0) ||
                      (rsp_data.page_index == last_index_ff) ||
                      ({1'b0, rsp_data.page_index} == last_next);

   // Index of the last delivered item
   always_ff @(posedge clock) begin
      if (reset) begin
         have_last_ff <= 1'b0;
      end else if (rsp_fire) begin
         have_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         last_index_ff <= rsp_data.page_index;
      end
   end

   `TPBF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid,
      "result valid after reset")

   `TPBF_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      rsp_valid && rsp_stall, "input stalled with the output slot free")

   `TPBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled item changed")

   `TPBF_ASSERT_NOW(a_index_same_page, clock, reset,
      rsp_fire && have_last_ff && !rsp_data.page_start,
      rsp_data.page_index == last_index_ff, "page index moved without a page start")

   `TPBF_ASSERT_NOW(a_index_step, clock, reset,
      rsp_fire && have_last_ff && rsp_data.page_start,
      index_ok, "page start with an index that skips pages")

endmodule

bind text_page_break_finder_core tpbf_checker u_tpbf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/text_page_break_finder_core_test.sv
// Self-checking testbench of the text page break finder: directed texts, full-rate pages and random text.
`timescale 1ns / 100ps

module text_page_break_finder_core_test;

   localparam int PAGE_BITS = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int PAGE_RUN_BYTES = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BYTES = 50;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef enum logic [1:0] {ESC_NONE, ESC_TICK, ESC_CARET} esc_phase_type;
   typedef logic [7:0] text_type[$];

   // Clock and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   tpbf_pkg::req_type req_data = '0;
   logic rsp_stall = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [tpbf_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [tpbf_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;

   logic req_stall;
   logic rsp_valid;
   tpbf_pkg::rsp_type rsp_data;
   logic [tpbf_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   always #6 clock = ~clock;

   text_page_break_finder_core #(.PAGE_COUNT_BITS(PAGE_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Register copies used by the page predictor
   logic [7:0] len_cfg = tpbf_pkg::PAGE_LENGTH_RESET;
   logic raw_cfg = tpbf_pkg::RAW_OUTPUT_RESET;
   logic [7:0] width_cfg = tpbf_pkg::LINE_WIDTH_RESET;

   // Predicted text state
   logic [7:0] col_no = 8'd1;
   logic [8:0] line_no = 9'd1;
   esc_phase_type esc_phase = ESC_NONE;
   logic hold_break = 1'b0;
   logic [PAGE_BITS-1:0] page_no = '0;
   logic text_open = 1'b0;

   tpbf_pkg::rsp_type expected_pages[$];
   int unsigned page_mismatches = 0;
   int unsigned bytes_sent = 0;
   int unsigned bytes_checked = 0;
   int unsigned breaks_seen = 0;
   int unsigned settings_used = 0;

   // Sender pacing and receiver stall control
   bit pacing = 1'b1;
   bit stall_enable = 1'b1;
   int unsigned burst_left = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned window_left = 0;
   int unsigned stall_odds = 0;

   function automatic void clear_text();
      col_no = 8'd1;
      line_no = 9'd1;
      esc_phase = ESC_NONE;
      hold_break = 1'b0;
      page_no = '0;
      text_open = 1'b0;
   endfunction

   function automatic void bump_line();
      if (line_no != tpbf_pkg::LINE_MAX) line_no++;
   endfunction

   // Column and line accounting of one character; a colour code tail takes no column
   function automatic void place_glyph(input logic [7:0] ch, input logic no_width);
      logic [7:0] prior;
      if (no_width && col_no != 8'd0) col_no--;
      if (ch == tpbf_pkg::CH_NL) begin
         col_no = 8'd1;
         bump_line();
         return;
      end
      prior = col_no;
      if (col_no != tpbf_pkg::COLUMN_MAX) col_no++;
      if (prior > width_cfg) begin
         if (line_no >= {1'b0, len_cfg}) begin
            hold_break = 1'b1;
         end else begin
            bump_line();
            col_no = 8'd1;
         end
      end
   endfunction

   // Page start and page index of one byte
   function automatic tpbf_pkg::rsp_type predict_page(input logic [7:0] ch, input logic last);
      tpbf_pkg::rsp_type result;
      logic opens;
      opens = 1'b0;
      if (!text_open) begin
         text_open = 1'b1;
         opens = 1'b1;
      end
      if (esc_phase == ESC_NONE) begin
         if (len_cfg != 8'd0 && line_no > {1'b0, len_cfg} && !hold_break) begin
            if (page_no != '1) page_no++;
            col_no = 8'd1;
            line_no = 9'd1;
            opens = 1'b1;
         end
         hold_break = 1'b0;
         if (!raw_cfg && ch == tpbf_pkg::CH_TICK) esc_phase = ESC_TICK;
         else place_glyph(ch, 1'b0);
      end else if (esc_phase == ESC_TICK) begin
         if (ch == tpbf_pkg::CH_TICK) begin
            place_glyph(ch, 1'b0);
            esc_phase = ESC_NONE;
         end else if (ch == tpbf_pkg::CH_CARET) begin
            esc_phase = ESC_CARET;
         end else begin
            place_glyph(ch, 1'b1);
            esc_phase = ESC_NONE;
         end
      end else begin
         place_glyph(ch, 1'b1);
         esc_phase = ESC_NONE;
      end
      result.page_start = opens;
      result.page_index = (page_no > tpbf_pkg::INDEX_MAX) ? tpbf_pkg::INDEX_MAX : page_no[15:0];
      if (last) clear_text();
      return result;
   endfunction

   function automatic void log_mismatch(input string what, input tpbf_pkg::rsp_type want,
                                        input tpbf_pkg::rsp_type seen);
      page_mismatches++;
      if (page_mismatches <= 10)
         $display("mismatch on %s: expected start %0b index %0d, got start %0b index %0d",
                  what, want.page_start, want.page_index, seen.page_start, seen.page_index);
   endfunction

   // Result checker: each accepted item against the oldest prediction
   always @(posedge clock) begin : check_results
      tpbf_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pages.size() == 0) begin
            log_mismatch("unexpected item", '0, rsp_data);
         end else begin
            want = expected_pages.pop_front();
            if (rsp_data.page_start !== want.page_start)
               log_mismatch("page_start", want, rsp_data);
            if (rsp_data.page_index !== want.page_index)
               log_mismatch("page_index", want, rsp_data);
            bytes_checked++;
            if (rsp_data.page_start) breaks_seen++;
         end
      end
   end

   // Receiver stall: long hold-off on request, else windows of random stall density
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!stall_enable) begin
         rsp_stall <= 1'b0;
      end else begin
         if (window_left == 0) begin
            window_left <= $urandom_range(1, 40);
            stall_odds <= $urandom_range(0, 3);
         end else begin
            window_left <= window_left - 1;
         end
         rsp_stall <= ($urandom_range(0, 3) < stall_odds);
      end
   end

   // Offer one byte, in bursts with random gaps, and predict its result on acceptance
   task automatic send_byte(input logic [7:0] ch, input logic last);
      int unsigned gap;
      if (pacing && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0) burst_left--;
      req_valid <= 1'b1;
      req_data <= '{text_byte: ch, end_of_text: last};
      do @(posedge clock); while (req_stall);
      expected_pages = {expected_pages, predict_page(ch, last)};
      bytes_sent++;
   endtask

   task automatic send_text(input text_type text, input bit end_it);
      foreach (text[i]) send_byte(text[i], end_it && i == text.size() - 1);
   endtask

   // Stop offering and wait until every predicted result has arrived
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_pages.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write (setup, access) followed by a read-back
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      logic [7:0] held;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         tpbf_pkg::REG_PAGE_LENGTH: len_cfg = value;
         tpbf_pkg::REG_RAW_OUTPUT: raw_cfg = value[0];
         tpbf_pkg::REG_LINE_WIDTH: width_cfg = value;
         default: ;
      endcase
      settings_used++;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         tpbf_pkg::REG_PAGE_LENGTH: held = len_cfg;
         tpbf_pkg::REG_RAW_OUTPUT: held = {7'd0, raw_cfg};
         tpbf_pkg::REG_LINE_WIDTH: held = width_cfg;
         default: held = 8'd0;
      endcase
      if (idx != REG_UNUSED && csr_prdata[7:0] !== held) begin
         page_mismatches++;
         if (page_mismatches <= 10)
            $display("register %0d read back %0h, expected %0h", idx, csr_prdata[7:0], held);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_registers(input logic [7:0] len, input logic raw, input logic [7:0] width);
      write_reg(tpbf_pkg::REG_PAGE_LENGTH, len);
      write_reg(tpbf_pkg::REG_RAW_OUTPUT, {7'd0, raw});
      write_reg(tpbf_pkg::REG_LINE_WIDTH, width);
   endtask

   // Random text: many newlines and colour codes, other bytes from 1 to 255
   function automatic logic [7:0] pick_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25) return tpbf_pkg::CH_NL;
      if (r < 40) return tpbf_pkg::CH_TICK;
      if (r < 46) return tpbf_pkg::CH_CARET;
      return 8'($urandom_range(1, 255));
   endfunction

   // Reset values: colour codes, doubled tick, caret code, extreme bytes
   task automatic test_default_settings();
      text_type text;
      text = {8'h01, tpbf_pkg::CH_TICK, 8'h72, 8'hFF, tpbf_pkg::CH_TICK, tpbf_pkg::CH_TICK,
              tpbf_pkg::CH_TICK, tpbf_pkg::CH_CARET, 8'h78, 8'h79, tpbf_pkg::CH_NL};
      send_text(text, 1'b1);
      wait_for_results();
   endtask

   // One-line pages with zero width: wraps held on the last line, breaks after escapes,
   // and a text that ends inside a colour code
   task automatic test_short_pages();
      text_type text;
      set_registers(8'd1, 1'b0, 8'd0);
      text = {8'h61, 8'h62, tpbf_pkg::CH_NL, 8'h63, tpbf_pkg::CH_TICK, tpbf_pkg::CH_CARET,
              8'h71, tpbf_pkg::CH_NL, tpbf_pkg::CH_TICK, tpbf_pkg::CH_NL, 8'h7A,
              tpbf_pkg::CH_TICK};
      send_text(text, 1'b1);
      wait_for_results();
   endtask

   // Paging disabled, raw output, wide line of 200 columns
   task automatic test_paging_off();
      text_type text;
      set_registers(8'd0, 1'b1, 8'd200);
      text = {tpbf_pkg::CH_NL, tpbf_pkg::CH_TICK, 8'h41, tpbf_pkg::CH_NL, tpbf_pkg::CH_NL,
              8'h80};
      send_text(text, 1'b1);
      wait_for_results();
   endtask

   // Unused register index is ignored; a write between bytes of one text applies onward
   task automatic test_register_writes();
      text_type text;
      set_registers(8'd2, 1'b0, 8'd1);
      write_reg(REG_UNUSED, 8'hFF);
      text = {8'h61, 8'h62, tpbf_pkg::CH_NL, 8'h63};
      send_text(text, 1'b0);
      wait_for_results();
      write_reg(tpbf_pkg::REG_LINE_WIDTH, 8'd3);
      text = {8'h64, 8'h65, 8'h66, tpbf_pkg::CH_NL, 8'h67};
      send_text(text, 1'b1);
      wait_for_results();
   endtask

   // Receiver holds off long enough for the block to stall its input
   task automatic test_output_holdoff();
      set_registers(8'd2, 1'b0, 8'd4);
      hold_requests++;
      repeat (24) send_byte(pick_byte(), 1'b0);
      send_byte(tpbf_pkg::CH_NL, 1'b1);
      wait_for_results();
   endtask

   // One newline per page, back to back with no receiver stalls
   task automatic test_full_rate_pages();
      pacing = 1'b0;
      stall_enable = 1'b0;
      set_registers(8'd1, 1'b0, 8'd200);
      for (int i = 0; i < PAGE_RUN_BYTES; i++)
         send_byte(tpbf_pkg::CH_NL, i == PAGE_RUN_BYTES - 1);
      wait_for_results();
      pacing = 1'b1;
      stall_enable = 1'b1;
   endtask

   // Random text over several register settings, extremes first
   task automatic test_random_text();
      logic [7:0] len;
      logic [7:0] width;
      logic raw;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               len = 8'd255;
               width = 8'd200;
               raw = 1'b0;
            end
            1: begin
               len = 8'd0;
               width = 8'd1;
               raw = 1'b1;
            end
            2: begin
               len = 8'd1;
               width = 8'd200;
               raw = 1'b0;
            end
            default: begin
               len = 8'($urandom_range(1, 5));
               width = 8'($urandom_range(1, 12));
               raw = ($urandom_range(0, 3) == 0);
            end
         endcase
         set_registers(len, raw, width);
         repeat (PHASE_BYTES) send_byte(pick_byte(), $urandom_range(0, 39) == 0);
         wait_for_results();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_settings();
      test_short_pages();
      test_paging_off();
      test_register_writes();
      test_output_holdoff();
      test_full_rate_pages();
      test_random_text();
      wait_for_results();
      repeat (8) @(posedge clock);
      $display("%0d text bytes checked, %0d of them page starts, including a full-rate page run",
               bytes_checked, breaks_seen);
      $display("%0d register writes across paging, width and raw output settings",
               settings_used);
      if (page_mismatches == 0 && expected_pages.size() == 0 && bytes_checked == bytes_sent)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Run limit, far above the slowest correct run
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
